[rtl/core/assert_macros.svh]
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on aclk, off during reset
`define ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on aclk, off during reset
`define ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/cbm_pkg.sv]
// types and constants of the cartridge bank mapper
`default_nettype none

package cbm_pkg;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_REDUCE,
        ST_COMMIT
    } state_t;

    // bank register operation of one access
    typedef enum logic [2:0] {
        OP_NONE,
        OP_RAM_EN,
        OP_ROM,
        OP_RAM_SEL,
        OP_MODE
    } op_t;

    // controller kinds
    localparam logic [2:0] KIND_NONE   = 3'd0;
    localparam logic [2:0] KIND_MBC1   = 3'd1;
    localparam logic [2:0] KIND_MBC2   = 3'd2;
    localparam logic [2:0] KIND_MBC3   = 3'd3;
    localparam logic [2:0] KIND_MBC5   = 3'd4;
    localparam logic [2:0] KIND_RUMBLE = 3'd5;
    localparam logic [2:0] KIND_HUC1   = 3'd6;

    // result targets
    localparam logic [2:0] TGT_REG  = 3'd0;
    localparam logic [2:0] TGT_BOOT = 3'd1;
    localparam logic [2:0] TGT_ROM  = 3'd2;
    localparam logic [2:0] TGT_CRAM = 3'd3;
    localparam logic [2:0] TGT_IRAM = 3'd4;
    localparam logic [2:0] TGT_IO   = 3'd5;

    // configuration register indexes
    localparam logic [1:0] REG_KIND     = 2'd0;
    localparam logic [1:0] REG_ROM_BANKS = 2'd1;
    localparam logic [1:0] REG_RAM_BANKS = 2'd2;
    localparam logic [1:0] REG_BOOT     = 2'd3;

    // bank register regions, address bits 14:13 below 0x8000
    localparam logic [1:0] RGN_RAM_EN = 2'd0;
    localparam logic [1:0] RGN_ROM    = 2'd1;
    localparam logic [1:0] RGN_UPPER  = 2'd2;
    localparam logic [1:0] RGN_MODE   = 2'd3;

    // fixed addresses and codes
    localparam logic [15:0] ADDR_BOOT_OFF = 16'hFF50;
    localparam logic [7:0]  BOOT_OFF_DATA = 8'h01;
    localparam logic [3:0]  RAM_EN_CODE   = 4'hA;

    // restoring reduction: one step per bit of the 9-bit bank value
    localparam int          SEL_W         = 9;
    localparam logic [3:0]  REDUCE_STEPS  = 4'd9;

endpackage

`default_nettype wire

[rtl/core/cartridge_bank_mapper.sv]
// cartridge bank mapper: cpu access to mapped target, bank and offset
// Usage: one cpu bus access is a word on the s_ channel (s_tuser = write flag,
// s_tdata = address and write byte); each access gives exactly one word on
// the m_ channel (m_tuser = target, m_tdata = bank, offset and flags).
// An apb-style port sets the controller kind, rom and ram bank counts and
// boot overlay presence; the user must see that it is written only while
// the block is idle, as the block itself does not enforce this.
// Sequence: a read, or a write that needs no bank reduction, passes through
// decode and commit before its word shows. A rom or ram bank select write
// runs a shared restoring reduce unit, one bit per cycle over the 9-bit bank
// value, and passes through decode, 9 steps and commit. One access at a time;
// s_tready comes back the cycle after the commit hands its word over.
// The output register holds a finished word while the receiver stalls; the
// commit step waits for that register to drain and bank state is updated
// only when the word is handed over.
// Reset (synchronous, aresetn low): configuration returns to kind none, two
// rom banks, one ram bank, no boot overlay; rom bank 1, ram bank 0, ram off,
// mode 0, and the output channel empties.
`default_nettype none

module cartridge_bank_mapper (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // access channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // address[15:0], write_data[23:16]
    input  wire logic [0:0]  s_tuser,   // func[0]
    // result channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // bank[6:0], offset[21:7],
                                        // ram_disabled_error[22], rumble[23]
    output logic [2:0]       m_tuser    // target[2:0]
);

    // configuration registers
    logic [2:0] kind_reg;
    logic [7:0] rom_banks_reg;
    logic [4:0] ram_banks_reg;
    logic       boot_present_reg;

    // controller state
    logic [cbm_pkg::SEL_W-1:0] rom_sel_reg;
    logic [3:0] ram_sel_reg;
    logic       ram_en_reg;
    logic       mode_reg;
    logic       boot_active_reg;

    // captured access
    logic        func_reg;
    logic [15:0] addr_reg;
    logic [7:0]  data_reg;

    // shared reduce unit
    logic [cbm_pkg::SEL_W-1:0] rem_reg;
    logic [cbm_pkg::SEL_W-1:0] dvd_reg;
    logic [7:0]                mod_reg;
    logic [3:0]                cnt_reg;

    // output register
    logic        m_tvalid_reg;
    logic [23:0] m_tdata_reg;
    logic [2:0]  m_tuser_reg;

    cbm_pkg::state_t state_reg, state_next;

    logic                      cfg_wr;
    logic                      mbc5_fam;
    logic                      b8;
    logic                      reg_write;
    cbm_pkg::op_t              op;
    logic [cbm_pkg::SEL_W-1:0] raw;
    logic [7:0]                modulus;
    logic                      boot_clr;
    logic [2:0]                tgt;
    logic [6:0]                bank;
    logic [14:0]               off;
    logic                      err;
    logic                      rum;
    logic [cbm_pkg::SEL_W-1:0] trial;
    logic [cbm_pkg::SEL_W-1:0] trial_sub;
    logic                      trial_ge;
    logic [cbm_pkg::SEL_W-1:0] rom_fin;
    logic                      out_free;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign s_tready = (state_reg == cbm_pkg::ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    // register read-back
    always_comb begin
        prdata = 32'd0;
        unique case (paddr[3:2])
            cbm_pkg::REG_KIND:      prdata = {29'd0, kind_reg};
            cbm_pkg::REG_ROM_BANKS: prdata = {24'd0, rom_banks_reg};
            cbm_pkg::REG_RAM_BANKS: prdata = {27'd0, ram_banks_reg};
            cbm_pkg::REG_BOOT:      prdata = {31'd0, boot_present_reg};
            default:                prdata = 32'd0;
        endcase
    end

    // bank register decode of the captured access
    assign mbc5_fam  = (kind_reg == cbm_pkg::KIND_MBC5) || (kind_reg == cbm_pkg::KIND_RUMBLE);
    assign b8        = addr_reg[8];
    assign reg_write = func_reg && !addr_reg[15];
    assign boot_clr  = func_reg && (addr_reg == cbm_pkg::ADDR_BOOT_OFF)
                       && (data_reg == cbm_pkg::BOOT_OFF_DATA);

    always_comb begin
        op  = cbm_pkg::OP_NONE;
        raw = rom_sel_reg;
        if (reg_write) begin
            case (addr_reg[14:13])
                cbm_pkg::RGN_RAM_EN: begin
                    if (kind_reg != cbm_pkg::KIND_MBC2 || !b8) begin
                        op = cbm_pkg::OP_RAM_EN;
                    end
                end
                cbm_pkg::RGN_ROM: begin
                    op = cbm_pkg::OP_ROM;
                    case (kind_reg) inside
                        cbm_pkg::KIND_MBC1, cbm_pkg::KIND_HUC1: begin
                            raw = {rom_sel_reg[8:5], data_reg[4:0]};
                        end
                        cbm_pkg::KIND_MBC2: begin
                            raw = b8 ? {rom_sel_reg[8:4], data_reg[3:0]} : rom_sel_reg;
                        end
                        cbm_pkg::KIND_MBC3: begin
                            raw = {rom_sel_reg[8:7], data_reg[6:0]};
                        end
                        cbm_pkg::KIND_MBC5, cbm_pkg::KIND_RUMBLE: begin
                            raw = addr_reg[12] ? {data_reg[0], rom_sel_reg[7:0]}
                                               : {rom_sel_reg[8], data_reg};
                        end
                        default: raw = '0;
                    endcase
                end
                cbm_pkg::RGN_UPPER: begin
                    case (kind_reg) inside
                        cbm_pkg::KIND_MBC1, cbm_pkg::KIND_HUC1: begin
                            if (mode_reg) begin
                                op  = cbm_pkg::OP_RAM_SEL;
                                raw = {7'd0, data_reg[1:0]};
                            end else begin
                                op  = cbm_pkg::OP_ROM;
                                raw = {1'b0, data_reg[7:5], rom_sel_reg[4:0]};
                            end
                        end
                        cbm_pkg::KIND_MBC5: begin
                            op  = cbm_pkg::OP_RAM_SEL;
                            raw = {5'd0, data_reg[3:0]};
                        end
                        cbm_pkg::KIND_RUMBLE: begin
                            op  = cbm_pkg::OP_RAM_SEL;
                            raw = {6'd0, data_reg[2:0]};
                        end
                        default: op = cbm_pkg::OP_NONE;
                    endcase
                end
                default: op = cbm_pkg::OP_MODE;
            endcase
        end
    end

    assign modulus = (op == cbm_pkg::OP_ROM) ? rom_banks_reg : {3'd0, ram_banks_reg};

    // result fields, from state before this access
    always_comb begin
        tgt = cbm_pkg::TGT_REG;
        bank = '0;
        off  = '0;
        err  = 1'b0;
        rum  = 1'b0;
        if (addr_reg[15]) begin
            if (addr_reg[15:13] == 3'b101) begin
                tgt  = cbm_pkg::TGT_CRAM;
                bank = {3'd0, ram_sel_reg};
                off  = {2'd0, addr_reg[12:0]};
                err  = !ram_en_reg;
            end else if (addr_reg[15:8] == 8'hFF) begin
                tgt = cbm_pkg::TGT_IO;
                off = addr_reg[14:0];
            end else begin
                tgt = cbm_pkg::TGT_IRAM;
                off = addr_reg[14:0];
            end
        end else if (func_reg) begin
            rum = (kind_reg == cbm_pkg::KIND_RUMBLE)
                  && (addr_reg[14:13] == cbm_pkg::RGN_UPPER) && data_reg[3];
        end else if (boot_active_reg && (addr_reg[14:8] == 7'd0)) begin
            tgt = cbm_pkg::TGT_BOOT;
            off = addr_reg[14:0];
        end else if (!addr_reg[14]) begin
            tgt = cbm_pkg::TGT_ROM;
            off = addr_reg[14:0];
        end else begin
            tgt  = cbm_pkg::TGT_ROM;
            bank = rom_sel_reg[6:0];
            off  = {1'b0, addr_reg[13:0]};
        end
    end

    // one restoring step of the shared reduce unit
    assign trial     = {rem_reg[7:0], dvd_reg[cbm_pkg::SEL_W-1]};
    assign trial_ge  = (trial >= {1'b0, mod_reg});
    assign trial_sub = trial - {1'b0, mod_reg};

    // rom bank 0 becomes 1 except on the mbc5 family
    assign rom_fin = (!mbc5_fam && rem_reg == '0) ? 9'd1 : rem_reg;

    // sequencer next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            cbm_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = cbm_pkg::ST_DECODE;
                end
            end
            cbm_pkg::ST_DECODE: begin
                if ((op == cbm_pkg::OP_ROM || op == cbm_pkg::OP_RAM_SEL) && modulus != '0) begin
                    state_next = cbm_pkg::ST_REDUCE;
                end else begin
                    state_next = cbm_pkg::ST_COMMIT;
                end
            end
            cbm_pkg::ST_REDUCE: begin
                if (cnt_reg == 4'd1) begin
                    state_next = cbm_pkg::ST_COMMIT;
                end
            end
            cbm_pkg::ST_COMMIT: begin
                if (out_free) begin
                    state_next = cbm_pkg::ST_IDLE;
                end
            end
            default: state_next = cbm_pkg::ST_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cbm_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // configuration and controller state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg         <= cbm_pkg::KIND_NONE;
            rom_banks_reg    <= 8'd2;
            ram_banks_reg    <= 5'd1;
            boot_present_reg <= 1'b0;
            rom_sel_reg      <= 9'd1;
            ram_sel_reg      <= 4'd0;
            ram_en_reg       <= 1'b0;
            mode_reg         <= 1'b0;
            boot_active_reg  <= 1'b0;
        end else begin
            if (cfg_wr) begin
                case (paddr[3:2])
                    cbm_pkg::REG_KIND:      kind_reg      <= pwdata[2:0];
                    cbm_pkg::REG_ROM_BANKS: rom_banks_reg <= pwdata[7:0];
                    cbm_pkg::REG_RAM_BANKS: ram_banks_reg <= pwdata[4:0];
                    default: begin
                        boot_present_reg <= pwdata[0];
                        boot_active_reg  <= pwdata[0];
                    end
                endcase
            end
            // bank state changes as the word is handed over
            if (state_reg == cbm_pkg::ST_COMMIT && out_free) begin
                if (boot_clr) begin
                    boot_active_reg <= 1'b0;
                end
                case (op)
                    cbm_pkg::OP_RAM_EN:  ram_en_reg  <= (data_reg[3:0] == cbm_pkg::RAM_EN_CODE);
                    cbm_pkg::OP_ROM:     rom_sel_reg <= rom_fin;
                    cbm_pkg::OP_RAM_SEL: ram_sel_reg <= rem_reg[3:0];
                    cbm_pkg::OP_MODE: begin
                        mode_reg    <= data_reg[0];
                        ram_sel_reg <= 4'd0;
                    end
                    default: ram_sel_reg <= ram_sel_reg;
                endcase
            end
        end
    end

    // access capture and reduce unit
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            func_reg <= s_tuser[0];
            addr_reg <= s_tdata[15:0];
            data_reg <= s_tdata[23:16];
        end
        if (state_reg == cbm_pkg::ST_DECODE) begin
            mod_reg <= modulus;
            dvd_reg <= raw;
            cnt_reg <= cbm_pkg::REDUCE_STEPS;
            rem_reg <= (modulus == '0) ? raw : '0;
        end else if (state_reg == cbm_pkg::ST_REDUCE) begin
            rem_reg <= trial_ge ? trial_sub : trial;
            dvd_reg <= {dvd_reg[cbm_pkg::SEL_W-2:0], 1'b0};
            cnt_reg <= cnt_reg - 4'd1;
        end
    end

    // output word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (state_reg == cbm_pkg::ST_COMMIT && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == cbm_pkg::ST_COMMIT && out_free) begin
            m_tdata_reg <= {rum, err, off, bank};
            m_tuser_reg <= tgt;
        end
    end

    // checks
    `include "assert_macros.svh"

    `ASSERT_IMP(a_word_from_commit, $rose(m_tvalid_reg),
        $past(state_reg == cbm_pkg::ST_COMMIT), "output word without commit")
    `ASSERT_NXT(a_rom_sel_only_on_commit, state_reg != cbm_pkg::ST_COMMIT && !cfg_wr,
        $stable(rom_sel_reg), "rom bank changed outside commit")
    `ASSERT_IMP(a_rem_below_mod, state_reg == cbm_pkg::ST_REDUCE,
        !rem_reg[8] && (rem_reg[7:0] < mod_reg), "reduce remainder out of range")
    `ASSERT_NXT(a_reduce_ends, state_reg == cbm_pkg::ST_REDUCE && cnt_reg == 4'd1,
        state_reg == cbm_pkg::ST_COMMIT, "reduce did not end after last step")

endmodule

`default_nettype wire
